>>> hw/rtl/rcw_pkg.sv
// ============================================================================
// rcw_pkg - shared types, tables and helpers of the three-wheel rotor cipher
// Wheel wirings, reflector, mod-26 arithmetic, beat and config structs.
// ============================================================================
package rcw_pkg;

   localparam int ALPHA = 26;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);
   localparam int NSTG = 5;

   localparam logic [7:0] CHAR_A = 8'd65;
   localparam logic [7:0] CHAR_Z = 8'd90;
   localparam logic [4:0] LAST_POS = 5'(ALPHA - 1);

   // letter tables, first letter in the top byte
   localparam logic [8*ALPHA-1:0] TAB0 = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
   localparam logic [8*ALPHA-1:0] TAB1 = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
   localparam logic [8*ALPHA-1:0] TAB2 = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
   localparam logic [8*ALPHA-1:0] TAB3 = "EJMZALYXVBWFCRQUDSOGPTHKIN";
   localparam logic [8*ALPHA-1:0] REFL = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

   typedef logic [4:0] map_type [ALPHA];
   typedef map_type wheel_maps_type [3];

   typedef enum logic [2:0] {
      CSR_PLUG_A_TO_L = 3'd0,
      CSR_PLUG_M_TO_X = 3'd1,
      CSR_PLUG_Y_TO_Z = 3'd2,
      CSR_FAST_WHEEL  = 3'd3,
      CSR_MID_WHEEL   = 3'd4,
      CSR_SLOW_WHEEL  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       message_start;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_valid;
   } rsp_type;

   typedef struct packed {
      logic [4:0] fast;
      logic [4:0] middle;
      logic [4:0] slow;
   } pos_type;

   typedef struct packed {
      logic [4:0] idx;
      logic       is_letter;
      pos_type    pos;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_beat_type;

   typedef struct packed {
      logic [ALPHA-1:0][4:0] plug_off;
      logic [1:0]            sel_fast;
      logic [1:0]            sel_mid;
      logic [1:0]            sel_slow;
   } cfg_type;

   function automatic logic [4:0] letter_at(input logic [8*ALPHA-1:0] t, input int i);
      logic [7:0] c;
      c = t[8*(ALPHA-1-i) +: 8];
      return 5'(c - CHAR_A);
   endfunction

   function automatic map_type inv_map(input logic [8*ALPHA-1:0] t);
      map_type m;
      for (int i = 0; i < ALPHA; i++) begin
         m[letter_at(t, i)] = 5'(i);
      end
      return m;
   endfunction

   // forward wheel: exit inverse of entry letter
   function automatic map_type build_fwd(input logic [8*ALPHA-1:0] e,
                                         input logic [8*ALPHA-1:0] x);
      map_type xinv;
      map_type r;
      xinv = inv_map(x);
      for (int k = 0; k < ALPHA; k++) begin
         r[k] = xinv[letter_at(e, k)];
      end
      return r;
   endfunction

   localparam wheel_maps_type FWD_TAB = '{build_fwd(TAB0, TAB1),
                                          build_fwd(TAB2, TAB3),
                                          build_fwd(TAB1, TAB0)};
   localparam wheel_maps_type REV_TAB = '{build_fwd(TAB1, TAB0),
                                          build_fwd(TAB3, TAB2),
                                          build_fwd(TAB0, TAB1)};
   localparam map_type REFL_INV = inv_map(REFL);

   function automatic logic [1:0] wheel_num(input logic [1:0] s);
      return (s == 2'd3) ? 2'd2 : s;
   endfunction

   function automatic logic [4:0] add_mod(input logic [4:0] a, input logic [4:0] b);
      logic [5:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= 6'(ALPHA)) ? 5'(s - 6'(ALPHA)) : 5'(s);
   endfunction

   function automatic logic [4:0] sub_mod(input logic [4:0] a, input logic [4:0] p);
      return (a >= p) ? 5'(a - p) : 5'(6'(a) + 6'(ALPHA) - 6'(p));
   endfunction

   // offsets may reach 31, so the sum can pass twice the alphabet
   function automatic logic [4:0] plug_map(input logic [ALPHA-1:0][4:0] off,
                                           input logic [4:0] x);
      logic [5:0] s;
      s = {1'b0, x} + {1'b0, off[x]};
      if (s >= 6'(2*ALPHA)) begin
         return 5'(s - 6'(2*ALPHA));
      end else if (s >= 6'(ALPHA)) begin
         return 5'(s - 6'(ALPHA));
      end
      return 5'(s);
   endfunction

   function automatic logic [4:0] wheel_fwd(input logic [1:0] w, input logic [4:0] p,
                                            input logic [4:0] i);
      return sub_mod(FWD_TAB[wheel_num(w)][add_mod(i, p)], p);
   endfunction

   function automatic logic [4:0] wheel_rev(input logic [1:0] w, input logic [4:0] p,
                                            input logic [4:0] i);
      return sub_mod(REV_TAB[wheel_num(w)][add_mod(i, p)], p);
   endfunction

   // odometer step of the three positions
   function automatic pos_type step_pos(input pos_type p);
      pos_type n;
      n = p;
      n.fast = (p.fast == LAST_POS) ? 5'd0 : 5'(p.fast + 5'd1);
      if (p.fast == LAST_POS) begin
         n.middle = (p.middle == LAST_POS) ? 5'd0 : 5'(p.middle + 5'd1);
         if (p.middle == LAST_POS) begin
            n.slow = (p.slow == LAST_POS) ? 5'd0 : 5'(p.slow + 5'd1);
         end
      end
      return n;
   endfunction

endpackage

>>> hw/rtl/rcw_front.sv
// ============================================================================
// rcw_front - input side of the rotor cipher
// Classifies each byte, owns the wheel positions and queues one job per beat.
// ============================================================================
module rcw_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rcw_pkg::req_type      req_data,
   input  logic                  q_full,
   output rcw_pkg::job_beat_type push
);

   rcw_pkg::pos_type pos_ff;
   rcw_pkg::pos_type pos_in;
   rcw_pkg::pos_type base;
   logic             accept;
   logic             is_letter;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign is_letter = (req_data.in_char >= rcw_pkg::CHAR_A) &&
                      (req_data.in_char <= rcw_pkg::CHAR_Z);

   always_comb begin
      base = req_data.message_start ? '0 : pos_ff;
      pos_in = pos_ff;
      if (accept) begin
         pos_in = is_letter ? rcw_pkg::step_pos(base) : base;
      end
      push.valid         = accept;
      push.job.pos       = base;
      push.job.is_letter = is_letter;
      push.job.idx       = is_letter ? 5'(req_data.in_char - rcw_pkg::CHAR_A) : 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

>>> hw/rtl/rcw_queue.sv
// ============================================================================
// rcw_queue - short job queue between front and back
// Lets the input side keep accepting while the cipher pipe is held.
// ============================================================================
module rcw_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  rcw_pkg::job_beat_type push,
   input  logic                  pop,
   output logic                  full,
   output rcw_pkg::job_beat_type head
);

   rcw_pkg::job_type                 mem_ff [rcw_pkg::QDEPTH];
   logic [rcw_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rcw_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rcw_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                             do_pop;

   assign full       = (cnt_ff == rcw_pkg::QCNT_W'(rcw_pkg::QDEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push.valid ? rcw_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rcw_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push.valid && !do_pop) begin
         cnt_in = rcw_pkg::QCNT_W'(cnt_ff + 1'b1);
      end else if (!push.valid && do_pop) begin
         cnt_in = rcw_pkg::QCNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

>>> hw/rtl/rcw_back.sv
// ============================================================================
// rcw_back - cipher pipeline of the rotor cipher
// Six stages: plug and wheels forward, reflector, wheels back, plug, result.
// ============================================================================
module rcw_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rcw_pkg::job_beat_type head,
   output logic                  pop,
   input  rcw_pkg::cfg_type      cfg,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rcw_pkg::rsp_type      rsp_data
);

   rcw_pkg::job_type        stg_ff [rcw_pkg::NSTG];
   rcw_pkg::job_type        stg_in [rcw_pkg::NSTG];
   logic [rcw_pkg::NSTG-1:0] vld_ff;
   logic [rcw_pkg::NSTG:0]   rdy;
   logic                    rsp_vld_ff;
   rcw_pkg::rsp_type        rsp_ff, rsp_in;
   logic [4:0]              last_idx;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
   assign pop       = head.valid && rdy[0];

   // advance a stage when it is empty or the next one moves
   always_comb begin
      rdy[rcw_pkg::NSTG] = !rsp_vld_ff || !rsp_stall;
      for (int k = rcw_pkg::NSTG - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      stg_in[0]     = head.job;
      stg_in[0].idx = rcw_pkg::wheel_fwd(cfg.sel_fast, head.job.pos.fast,
                         rcw_pkg::plug_map(cfg.plug_off, head.job.idx));
      stg_in[1]     = stg_ff[0];
      stg_in[1].idx = rcw_pkg::wheel_fwd(cfg.sel_mid, stg_ff[0].pos.middle, stg_ff[0].idx);
      stg_in[2]     = stg_ff[1];
      stg_in[2].idx = rcw_pkg::REFL_INV[rcw_pkg::wheel_fwd(cfg.sel_slow,
                         stg_ff[1].pos.slow, stg_ff[1].idx)];
      stg_in[3]     = stg_ff[2];
      stg_in[3].idx = rcw_pkg::wheel_rev(cfg.sel_slow, stg_ff[2].pos.slow, stg_ff[2].idx);
      stg_in[4]     = stg_ff[3];
      stg_in[4].idx = rcw_pkg::wheel_rev(cfg.sel_mid, stg_ff[3].pos.middle, stg_ff[3].idx);
      last_idx = rcw_pkg::plug_map(cfg.plug_off,
                    rcw_pkg::wheel_rev(cfg.sel_fast, stg_ff[4].pos.fast, stg_ff[4].idx));
      rsp_in.out_valid = stg_ff[4].is_letter;
      rsp_in.out_char  = stg_ff[4].is_letter ? 8'(rcw_pkg::CHAR_A + {3'b000, last_idx})
                                             : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= head.valid;
         end
         for (int k = 1; k < rcw_pkg::NSTG; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (rdy[rcw_pkg::NSTG]) begin
            rsp_vld_ff <= vld_ff[rcw_pkg::NSTG-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < rcw_pkg::NSTG; k++) begin
         if (rdy[k]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
      if (rdy[rcw_pkg::NSTG]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> hw/rtl/rotor_cipher_three_wheel_top.sv
// ============================================================================
// rotor_cipher_three_wheel_top - three-wheel rotor cipher, one byte per beat
// Plugboard, three selectable wheels, reflector; encode equals decode if plug_map is self-inverse.
// ============================================================================
// Every accepted request beat yields exactly one response beat, in order. An
// upper-case ASCII letter comes back enciphered with out_valid set and then
// steps the wheels like an odometer; any other byte comes back as zero with
// out_valid clear and leaves the wheels alone. message_start zeroes the three
// positions before its own byte is handled. The block takes one byte per clock
// while the queue is not full: the front owns the positions and pushes each
// byte with its position snapshot into a four-entry queue, and a six-stage
// cipher pipe (one wheel pass per stage, held by rsp_stall) drains that queue
// into the response register. Write the config registers through the csr
// port only while no beat is in flight; csr_ready is always high and indexes
// beyond the last register are dropped.
// ============================================================================
module rotor_cipher_three_wheel_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rcw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rcw_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [59:0]      csr_data
);

   logic [59:0]           plug_al_ff;
   logic [59:0]           plug_mx_ff;
   logic [9:0]            plug_yz_ff;
   logic [1:0]            sel_fast_ff;
   logic [1:0]            sel_mid_ff;
   logic [1:0]            sel_slow_ff;
   rcw_pkg::cfg_type      cfg;
   rcw_pkg::job_beat_type push;
   rcw_pkg::job_beat_type head;
   logic                  q_full;
   logic                  pop;

   assign csr_ready = 1'b1;

   // config registers; A sits in the low bits of the plug vector
   always_ff @(posedge clock) begin
      if (reset) begin
         plug_al_ff  <= '0;
         plug_mx_ff  <= '0;
         plug_yz_ff  <= '0;
         sel_fast_ff <= 2'd0;
         sel_mid_ff  <= 2'd1;
         sel_slow_ff <= 2'd2;
      end else if (csr_valid && csr_ready) begin
         unique case (rcw_pkg::csr_index_type'(csr_index))
            rcw_pkg::CSR_PLUG_A_TO_L: plug_al_ff  <= csr_data;
            rcw_pkg::CSR_PLUG_M_TO_X: plug_mx_ff  <= csr_data;
            rcw_pkg::CSR_PLUG_Y_TO_Z: plug_yz_ff  <= csr_data[9:0];
            rcw_pkg::CSR_FAST_WHEEL:  sel_fast_ff <= csr_data[1:0];
            rcw_pkg::CSR_MID_WHEEL:   sel_mid_ff  <= csr_data[1:0];
            rcw_pkg::CSR_SLOW_WHEEL:  sel_slow_ff <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.plug_off = {plug_yz_ff, plug_mx_ff, plug_al_ff};
   assign cfg.sel_fast = sel_fast_ff;
   assign cfg.sel_mid  = sel_mid_ff;
   assign cfg.sel_slow = sel_slow_ff;

   // front: classify, hold positions, queue the job
   rcw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push)
   );

   rcw_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   // back: run the wheels and hold the response beat
   rcw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push.valid)
      else $error("job pushed into full queue");

   // a letter result is upper case, a non-letter result is zero
   a_rsp_letter: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_valid) |->
         (rsp_data.out_char >= rcw_pkg::CHAR_A && rsp_data.out_char <= rcw_pkg::CHAR_Z))
      else $error("response letter out of range");

   a_rsp_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.out_valid) |-> (rsp_data.out_char == 8'd0))
      else $error("non-letter response not zero");

   // nothing leaves the pipe right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response beat right after reset");

endmodule
